### src/pwm_duty_meter_iir_assert.svh
// ----------------------------------------------------------------------------
// PWM duty meter assertion macros
// Shorthand for clocked checks with reset gating on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef PWM_DUTY_METER_IIR_ASSERT_SVH
`define PWM_DUTY_METER_IIR_ASSERT_SVH

// same-cycle implication
`define PDMI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pdmi_pkg.sv
// ----------------------------------------------------------------------------
// pdmi_pkg
// Widths, constants and shared types of the PWM duty meter.
// ----------------------------------------------------------------------------
package pdmi_pkg;

    localparam int TIME_W    = 32;              // edge timestamp width
    localparam int DUTY_W    = 16;              // Q15 duty, 0..32768
    localparam int QUO_BITS  = 16;              // quotient bits per divide
    localparam int CNT_W     = $clog2(QUO_BITS + 1);
    localparam int PCT_W     = 7;
    localparam int IIR_SHIFT = 3;               // filter gain 1/8
    localparam int PROD_W    = 22;              // 15-bit duty times 100 plus half

    localparam logic [14:0]       PCT_CLAMP = 15'h7FFF;
    localparam logic [6:0]        PCT_SCALE = 7'd100;
    localparam logic [PROD_W-1:0] PCT_HALF  = 22'd16384;

    // divider handshake, sequencer to divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // divider status, divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### src/pdmi_div.sv
// ----------------------------------------------------------------------------
// pdmi_div
// Restoring divider: (dividend << 15) / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pdmi_div
    import pdmi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctrl_t         ctrl,
    input  logic [TIME_W-1:0] dividend,   // must not exceed divisor
    input  logic [TIME_W-1:0] divisor,
    output div_stat_t         stat,
    output logic [DUTY_W-1:0] quotient
);

    logic [TIME_W:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]   den_reg;
    logic [DUTY_W-1:0]   quo_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                q_bit;
    logic [TIME_W:0]     rem_sub;

    // shared compare / subtract unit
    assign q_bit   = (rem_reg >= {1'b0, den_reg});
    assign rem_sub = q_bit ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_BITS);
            rem_next  = {1'b0, dividend};
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the shift fits
            rem_next = {rem_sub[TIME_W-1:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (ctrl.start)
        begin
            den_reg <= divisor;
        end
        if (busy_reg && !ctrl.start)
        begin
            quo_reg <= {quo_reg[DUTY_W-2:0], q_bit};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### src/pwm_duty_meter_iir.sv
// ----------------------------------------------------------------------------
// pwm_duty_meter_iir
// PWM duty meter: edge timestamps in, IIR-smoothed Q15 duty and percent out.
// ----------------------------------------------------------------------------
//  channel   dir  sideband   payload
//  s_axis    in   tuser=mode tdata = edge_time, capture_overflow
//  m_axis    out  -          tdata = duty, valid, percent, sample, overflow
//
//  A falling edge goes from idle straight to emit; a rise that yields no sample
//  passes the check state first, and one that yields a sample runs check, divide,
//  filter and emit. The divide state produces one quotient bit per cycle until done.
//  s_tready is high only while the sequencer is idle; one edge in flight.
//  A stalled output holds its beat; the next edge is accepted meanwhile and
//  waits in the emit state until the held beat leaves.
//  rst_n clears control, edge and filter state asynchronously; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "pwm_duty_meter_iir_assert.svh"

module pwm_duty_meter_iir
    import pdmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] edge_time, [32] capture_overflow, rest zero
    input  logic        s_tuser,   // [0] mode: 0 rise, 1 fall
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] filtered_duty, [16] duty_valid,
                                   // [23:17] percent, [24] sample_taken,
                                   // [25] overflow_seen, rest zero
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_FILT  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   latest_rise_reg;
    logic [TIME_W-1:0]   latest_fall_reg;
    logic                fall_pending_reg;
    logic                pend_snap_reg;
    logic [TIME_W-1:0]   period_reg;
    logic [TIME_W-1:0]   high_reg;
    logic [DUTY_W-1:0]   duty_filter_reg, duty_filter_next;
    logic                valid_flag_reg;
    logic                overflow_reg;
    logic                taken_reg;
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;

    logic                accept;
    logic                edge_fall;
    logic [TIME_W-1:0]   edge_time;
    logic                sample_ok;
    logic                out_free;
    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;
    logic [DUTY_W-1:0]   div_quo;
    logic [DUTY_W:0]     diff;
    logic [DUTY_W:0]     diff_mag;
    logic [DUTY_W-1:0]   step_mag;
    logic [14:0]         duty_clamped;
    logic [PROD_W-1:0]   pct_prod;
    logic [PCT_W-1:0]    pct_round;

    assign edge_fall = s_tuser;
    assign edge_time = s_tdata[TIME_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign sample_ok = (period_reg != '0) && pend_snap_reg && (high_reg <= period_reg);
    assign div_ctrl.start = (state_reg == ST_CHECK) && sample_ok;

    pdmi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (high_reg),
        .divisor  (period_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // y += (x - y) / 8, quotient truncated toward zero
    always_comb
    begin
        diff     = {1'b0, div_quo} - {1'b0, duty_filter_reg};
        diff_mag = diff[DUTY_W] ? (~diff + (DUTY_W+1)'(1)) : diff;
        step_mag = DUTY_W'(diff_mag >> IIR_SHIFT);
        duty_filter_next = diff[DUTY_W] ? (duty_filter_reg - step_mag)
                                        : (duty_filter_reg + step_mag);
    end

    always_comb
    begin
        duty_clamped = duty_filter_reg[15] ? PCT_CLAMP : duty_filter_reg[14:0];
        pct_prod     = PROD_W'(duty_clamped) * PROD_W'(PCT_SCALE) + PCT_HALF;
        pct_round    = pct_prod[PROD_W-1:15];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = edge_fall ? ST_EMIT : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sample_ok ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            latest_rise_reg  <= '0;
            latest_fall_reg  <= '0;
            fall_pending_reg <= 1'b0;
            duty_filter_reg  <= '0;
            valid_flag_reg   <= 1'b0;
            overflow_reg     <= 1'b0;
            taken_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                taken_reg <= 1'b0;
                if (s_tdata[TIME_W])
                begin
                    overflow_reg <= 1'b1;
                end
                if (edge_fall)
                begin
                    latest_fall_reg  <= edge_time;
                    fall_pending_reg <= 1'b1;
                end
                else
                begin
                    latest_rise_reg  <= edge_time;
                    fall_pending_reg <= 1'b0;
                end
            end
            if (state_reg == ST_FILT)
            begin
                duty_filter_reg <= duty_filter_next;
                valid_flag_reg  <= 1'b1;
                taken_reg       <= 1'b1;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // measurement operands and output beat
    always_ff @(posedge clk)
    begin
        if (accept && !edge_fall)
        begin
            period_reg    <= edge_time - latest_rise_reg;
            high_reg      <= latest_fall_reg - latest_rise_reg;
            pend_snap_reg <= fall_pending_reg;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_data_reg <= {6'd0, overflow_reg, taken_reg, pct_round,
                             valid_flag_reg, duty_filter_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PDMI_ASSERT_NOW(a_done_in_div, div_stat.done, state_reg == ST_DIV,
        "divider finished outside the divide state")
    `PDMI_ASSERT_NOW(a_busy_in_div, div_stat.busy, state_reg == ST_DIV,
        "divider busy outside the divide state")
    `PDMI_ASSERT_NOW(a_filter_range, 1'b1, duty_filter_reg <= 16'd32768,
        "filtered duty above full scale")
    `PDMI_ASSERT_NOW(a_sample_valid, m_tvalid && m_tdata[24], m_tdata[16],
        "sample reported without duty valid")
    `PDMI_ASSERT_NEXT(a_fall_short, accept && edge_fall, state_reg == ST_EMIT,
        "falling edge did not go straight to output")

endmodule

### verif/tb_pwm_duty_meter_iir.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pwm_duty_meter_iir
// Self-checking bench for the PWM duty meter. Streams captured rise and fall
// beats into the block and predicts every output beat in step: the stored
// rise and fall times, the Q15 duty division, the 1/8 smoothing filter, the
// rounded percent and the sticky overflow. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_pwm_duty_meter_iir;
    import pdmi_pkg::*;

    localparam bit EDGE_RISE = 1'b0;
    localparam bit EDGE_FALL = 1'b1;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CAPTURE_TARGET = 900;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              valid;
        logic [PCT_W-1:0]  pct;
        logic              sample;
        logic              ovf;
    } meter_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // shadow of the meter state
    logic [TIME_W-1:0] prior_rise_t;
    logic [TIME_W-1:0] last_rise_t;
    logic [TIME_W-1:0] last_fall_t;
    logic              fall_armed;
    logic [DUTY_W-1:0] filter_q;
    logic              have_duty;
    logic              ovf_sticky;

    meter_word_t       duty_words_due[$];
    int                mismatches = 0;
    int                captures_sent = 0;
    int                idle_cycles = 0;
    int                out_stall_left = 0;
    bit                pace_on = 1'b1;
    logic [TIME_W-1:0] gen_rise = '0;

    pwm_duty_meter_iir dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic meter_word_t predict_meter(bit is_fall, logic [TIME_W-1:0] stamp,
                                                  bit ovf);
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] high;
        logic [47:0]       num;
        logic [DUTY_W-1:0] duty;
        int                diff;
        int                clamped;
        meter_word_t       w;
        w.sample = 1'b0;
        if (ovf)
        begin
            ovf_sticky = 1'b1;
        end
        if (is_fall)
        begin
            last_fall_t = stamp;
            fall_armed = 1'b1;
        end
        else
        begin
            prior_rise_t = last_rise_t;
            last_rise_t = stamp;
            period = last_rise_t - prior_rise_t;
            high = last_fall_t - prior_rise_t;
            if (period != 0 && fall_armed && high <= period)
            begin
                num = {high, 15'b0};
                duty = 16'(num / period);
                // signed division truncates toward zero, as the filter needs
                diff = int'(duty) - int'(filter_q);
                filter_q = 16'(int'(filter_q) + diff / 8);
                have_duty = 1'b1;
                w.sample = 1'b1;
            end
            fall_armed = 1'b0;
        end
        clamped = (filter_q > 16'd32767) ? 32767 : int'(filter_q);
        w.duty = filter_q;
        w.valid = have_duty;
        w.pct = 7'((clamped * 100 + 16384) / 32768);
        w.ovf = ovf_sticky;
        return w;
    endfunction

    task automatic drive_capture(bit is_fall, logic [TIME_W-1:0] stamp, bit ovf);
        int gap;
        gap = pace_on ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= is_fall;
        s_tdata <= {7'b0, ovf, stamp};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        duty_words_due.push_back(predict_meter(is_fall, stamp, ovf));
        captures_sent++;
        if (!is_fall)
        begin
            gen_rise = stamp;
        end
    endtask

    // one full PWM cycle from the last rise: fall after high, rise after period
    task automatic send_cycle(logic [TIME_W-1:0] high, logic [TIME_W-1:0] period, bit ovf);
        drive_capture(EDGE_FALL, gen_rise + high, 1'b0);
        drive_capture(EDGE_RISE, gen_rise + period, ovf);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic test_reset_outputs();
        // fall at zero, then a rise at zero: zero period, nothing measured yet
        drive_capture(EDGE_FALL, 32'd0, 1'b0);
        drive_capture(EDGE_RISE, 32'd0, 1'b0);
    endtask

    task automatic test_edge_cases();
        drive_capture(EDGE_RISE, 32'd1000, 1'b0);          // no fall pending
        drive_capture(EDGE_FALL, 32'd1250, 1'b0);
        drive_capture(EDGE_RISE, 32'd2000, 1'b0);          // quarter duty
        drive_capture(EDGE_FALL, 32'd2100, 1'b0);
        drive_capture(EDGE_FALL, 32'd2600, 1'b0);          // later fall wins
        drive_capture(EDGE_RISE, 32'd3000, 1'b0);
        drive_capture(EDGE_FALL, 32'd5000, 1'b0);
        drive_capture(EDGE_RISE, 32'd4000, 1'b0);          // fall beyond the period
        drive_capture(EDGE_FALL, 32'd5000, 1'b0);
        drive_capture(EDGE_RISE, 32'd5000, 1'b0);          // high equals period
        drive_capture(EDGE_FALL, 32'd5000, 1'b0);
        drive_capture(EDGE_RISE, 32'd6000, 1'b0);          // zero high time
        drive_capture(EDGE_FALL, 32'd6500, 1'b0);
        drive_capture(EDGE_RISE, 32'd6000, 1'b0);          // zero period with fall pending
        drive_capture(EDGE_RISE, 32'hFFFF_FF00, 1'b0);
        drive_capture(EDGE_FALL, 32'h0000_0010, 1'b0);
        drive_capture(EDGE_RISE, 32'h0000_0100, 1'b0);     // timer wrap inside the cycle
        drive_capture(EDGE_FALL, 32'h0000_00FE, 1'b0);
        drive_capture(EDGE_RISE, 32'h0000_00FF, 1'b0);     // widest period
        drive_capture(EDGE_FALL, 32'hFFFF_FFFF, 1'b0);
        drive_capture(EDGE_RISE, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_overflow_flag();
        drive_capture(EDGE_FALL, 32'hFFFF_FFFF + 32'd40, 1'b1);
        drive_capture(EDGE_RISE, 32'hFFFF_FFFF + 32'd100, 1'b1);
        drive_capture(EDGE_FALL, 32'hFFFF_FFFF + 32'd150, 1'b0);
    endtask

    task automatic test_filter_extremes();
        logic [TIME_W-1:0] p;
        pace_on = 1'b0;
        drive_capture(EDGE_RISE, $urandom, 1'b0);
        // hold full duty until the percent saturates
        repeat (60)
        begin
            p = $urandom_range(8, 5000);
            send_cycle(p, p, 1'b0);
        end
        pace_on = 1'b1;
        repeat (30)
        begin
            send_cycle(32'd0, $urandom_range(1, 70000), 1'b0);
        end
    endtask

    task automatic test_random_pwm();
        int                pick;
        int                w;
        bit                ovf;
        logic [TIME_W-1:0] mask;
        logic [TIME_W-1:0] p;
        logic [TIME_W-1:0] h;
        longint unsigned   r;
        while (captures_sent < CAPTURE_TARGET)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                pace_on = !pace_on;
            end
            pick = $urandom_range(0, 99);
            ovf = ($urandom_range(0, 63) == 0);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
            mask = 32'((33'd1 << w) - 33'd1);
            p = $urandom & mask;
            r = {$urandom, $urandom};
            h = (p == 0) ? '0 : 32'(r % ({32'd0, p} + 64'd1));
            if (pick < 75)
            begin
                case ($urandom_range(0, 9))
                    0: send_cycle(p, p, ovf);
                    1: send_cycle(32'd0, p, ovf);
                    default: send_cycle(h, p, ovf);
                endcase
            end
            else if (pick < 82)
            begin
                drive_capture(EDGE_FALL, $urandom, ovf);
                send_cycle(h, p, 1'b0);
            end
            else if (pick < 88)
            begin
                drive_capture(EDGE_RISE, gen_rise + p, ovf);
            end
            else if (pick < 92)
            begin
                send_cycle(h, 32'd0, ovf);
            end
            else if (pick < 96)
            begin
                p = $urandom_range(1, 1 << 20);
                send_cycle(p + $urandom_range(1, 1000), p, ovf);
            end
            else
            begin
                drive_capture($urandom_range(0, 1), $urandom, ovf);
            end
        end
    endtask

    // output side: stall for a drawn number of cycles after each beat
    always @(negedge clk)
    begin
        if (out_stall_left > 0)
        begin
            m_tready <= 1'b0;
            out_stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        meter_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (duty_words_due.size() == 0)
            begin
                $display("%0t: unexpected output beat: expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = duty_words_due.pop_front();
                check_field("filtered_duty", want.duty, m_tdata[15:0]);
                check_field("duty_valid", want.valid, m_tdata[16]);
                check_field("percent", want.pct, m_tdata[23:17]);
                check_field("sample_taken", want.sample, m_tdata[24]);
                check_field("overflow_seen", want.ovf, m_tdata[25]);
                check_field("tdata padding", 0, m_tdata[31:26]);
            end
            out_stall_left = pace_on ? $urandom_range(0, 9) : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        prior_rise_t = '0;
        last_rise_t = '0;
        last_fall_t = '0;
        fall_armed = 1'b0;
        filter_q = '0;
        have_duty = 1'b0;
        ovf_sticky = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_outputs();
        test_edge_cases();
        test_overflow_flag();
        test_filter_extremes();
        test_random_pwm();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (duty_words_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/pdmi_pkg.sv
src/pdmi_div.sv
src/pwm_duty_meter_iir.sv
verif/tb_pwm_duty_meter_iir.sv
